/* sv/tcns_pkg.sv */
// tcns_pkg: shared types and constants of the timestamp calibration block
// used by tcns_ctrl, tcns_dp and timestamp_calibrate_to_ns_top
package tcns_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned WPS_W    = 10;
  localparam int unsigned RATE_W   = 64;
  localparam int unsigned NS_W     = 30;
  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned PROD_W   = MUL_A_W + NS_W;

  localparam logic [WPS_W-1:0] WPS_RESET  = 10'd100;
  localparam logic [NS_W-1:0]  NS_PER_SEC = 30'd1000000000;

  // item kinds; any kind with bit 1 set is a read
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_START = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_CAL   = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_NOCAL = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_POST,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic mul_lo;
    logic mul_hi;
    logic set_rate;
    logic div_load;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rate_zero;
    logic op_end;
    logic div_last;
  } sts_t;

endpackage

/* sv/tcns_ctrl.sv */
// tcns_ctrl: sequencer for one item at a time and the result valid flag
// depends on tcns_pkg; drives tcns_dp through cmd_t, reads sts_t
module tcns_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [tcns_pkg::KIND_W-1:0]     in_kind,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  input  tcns_pkg::sts_t                  sts,
  output tcns_pkg::cmd_t                  cmd
);
  import tcns_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;
  logic   out_free;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_kind == KIND_START) begin
            state_nxt = ST_DONE;
          end else if (in_kind == KIND_END) begin
            state_nxt = ST_MUL_LO;
          end else if (sts.rate_zero) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_MUL_LO;
          end
        end
      end
      ST_MUL_LO: state_nxt = ST_MUL_HI;
      ST_MUL_HI: state_nxt = ST_POST;
      ST_POST:   state_nxt = sts.op_end ? ST_DONE : ST_DIV;
      ST_DIV:    if (sts.div_last) state_nxt = ST_DONE;
      ST_DONE:   if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_xfer;
      end
      ST_MUL_LO: cmd.mul_lo = 1'b1;
      ST_MUL_HI: cmd.mul_hi = 1'b1;
      ST_POST: begin
        cmd.set_rate = sts.op_end;
        cmd.div_load = !sts.op_end;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // a finished result never overwrites one that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending transfer");

  // the divider only runs with a nonzero rate
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !sts.rate_zero)
    else $error("divide by zero rate");

  // one item at a time: no input transfer right after one
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input taken while busy");

endmodule

/* sv/tcns_dp.sv */
// tcns_dp: calibration state, shared 32x30 multiplier, bit-serial divider
// and output payload register; depends on tcns_pkg, steered by tcns_ctrl
module tcns_dp #(
  parameter int unsigned STAMP_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [tcns_pkg::KIND_W-1:0]      in_kind,
  input  logic [63:0]                      in_stamp,
  input  logic                             cfg_wr_en,
  input  logic [tcns_pkg::WPS_W-1:0]       cfg_wr_data,
  input  tcns_pkg::cmd_t                   cmd,
  output tcns_pkg::sts_t                   sts,
  output logic [2*tcns_pkg::RATE_W-1:0]    out_data,
  output logic [tcns_pkg::STATUS_W-1:0]    out_status
);
  import tcns_pkg::*;

  localparam int unsigned ACC_W = STAMP_WIDTH + NS_W;
  localparam int unsigned CNT_W = $clog2(ACC_W);

  logic [WPS_W-1:0]       wps_r;
  logic [STAMP_WIDTH-1:0] window_start_r;
  logic [STAMP_WIDTH-1:0] boot_r;
  logic [RATE_W-1:0]      rate_r;
  logic [STAMP_WIDTH-1:0] stamp_r;
  logic [STAMP_WIDTH-1:0] op_r;
  logic                   op_end_r;
  logic [STATUS_W-1:0]    res_status_r;
  logic [ACC_W-1:0]       acc_r;
  logic [RATE_W-1:0]      rem_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [RATE_W-1:0]      out_ns_r;
  logic [RATE_W-1:0]      out_rate_r;
  logic [STATUS_W-1:0]    out_status_r;

  logic [STAMP_WIDTH-1:0] stamp_in;
  logic [MUL_A_W-1:0]     mul_a;
  logic [NS_W-1:0]        mul_b;
  logic [PROD_W-1:0]      prod;
  logic [RATE_W:0]        r2;
  logic [RATE_W:0]        diff;
  logic                   q_bit;

  assign stamp_in = in_stamp[STAMP_WIDTH-1:0];

  // shared multiplier: low then high 32-bit half of the operand
  assign mul_a = cmd.mul_hi ? MUL_A_W'(op_r >> MUL_A_W) : op_r[MUL_A_W-1:0];
  assign mul_b = op_end_r ? NS_W'(wps_r) : NS_PER_SEC;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  // restoring divider step, one quotient bit per cycle
  assign r2    = {rem_r, acc_r[ACC_W-1]};
  assign diff  = r2 - {1'b0, rate_r};
  assign q_bit = (r2 >= {1'b0, rate_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wps_r          <= WPS_RESET;
      window_start_r <= '0;
      boot_r         <= '0;
      rate_r         <= '0;
    end else begin
      if (cfg_wr_en) wps_r <= cfg_wr_data;
      if (cmd.capture && in_kind == KIND_START) window_start_r <= stamp_in;
      if (cmd.set_rate) begin
        rate_r <= RATE_W'(acc_r);
        boot_r <= stamp_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      stamp_r  <= stamp_in;
      op_end_r <= (in_kind == KIND_END);
      op_r     <= (in_kind == KIND_END) ? stamp_in - window_start_r : stamp_in - boot_r;
      case (in_kind)
        KIND_START: res_status_r <= STAT_START;
        KIND_END:   res_status_r <= STAT_CAL;
        default:    res_status_r <= (rate_r == '0) ? STAT_NOCAL : STAT_OK;
      endcase
    end
    if (cmd.mul_lo) acc_r <= ACC_W'(prod);
    if (cmd.mul_hi) acc_r <= acc_r + ACC_W'({prod, {MUL_A_W{1'b0}}});
    if (cmd.div_load) begin
      rem_r <= '0;
      cnt_r <= CNT_W'(ACC_W - 1);
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? diff[RATE_W-1:0] : r2[RATE_W-1:0];
      acc_r <= {acc_r[ACC_W-2:0], q_bit};
      cnt_r <= cnt_r - 1'b1;
    end
    if (cmd.out_load) begin
      out_ns_r     <= (res_status_r == STAT_OK) ? RATE_W'(acc_r) : '0;
      out_rate_r   <= rate_r;
      out_status_r <= res_status_r;
    end
  end

  assign sts.rate_zero = (rate_r == '0);
  assign sts.op_end    = op_end_r;
  assign sts.div_last  = (cnt_r == '0);

  assign out_data   = {out_rate_r, out_ns_r};
  assign out_status = out_status_r;

endmodule

/* sv/timestamp_calibrate_to_ns_top.sv */
// timestamp_calibrate_to_ns_top: counter calibration and ns conversion
// window start and uncalibrated read go straight to the result register;
// window end passes the low and high multiply and post steps; a calibrated
// read also runs the restoring divider, which retires one quotient bit a cycle
// one item in flight; the next is taken the cycle after its result is registered
// rst_n (sync, active low) clears window start, rate, boot reference, sets wps 100
module timestamp_calibrate_to_ns_top #(
  parameter int unsigned STAMP_WIDTH = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [63:0]                         in_tdata,   // stamp
  input  logic [tcns_pkg::KIND_W-1:0]         in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [2*tcns_pkg::RATE_W-1:0]       out_tdata,  // nanoseconds, rate_hz
  output logic [tcns_pkg::STATUS_W-1:0]       out_tuser,  // status
  input  logic                                cfg_wr_en,
  input  logic [tcns_pkg::WPS_W-1:0]          cfg_wr_data // windows_per_second
);
  import tcns_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tcns_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_kind    (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  tcns_dp #(
    .STAMP_WIDTH (STAMP_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_kind     (in_tuser),
    .in_stamp    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_tdata),
    .out_status  (out_tuser)
  );

endmodule
